@@ sv/tvbd_pkg.sv @@
// tvbd_pkg: constants, register codes and round helpers for the tea-variant
// block decipher pipeline
// depends on nothing; used by tea_variant_block_decrypt
package tvbd_pkg;

  localparam int unsigned ROUNDS    = 16;
  localparam int unsigned STAGES    = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_COUNT = 4;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam logic [WORD_W-1:0] KEY0_RESET = 32'h5665_7824;
  localparam logic [WORD_W-1:0] KEY1_RESET = 32'h5674_5632;
  localparam logic [WORD_W-1:0] KEY2_RESET = 32'h9780_9879;
  localparam logic [WORD_W-1:0] KEY3_RESET = 32'h6576_7878;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [KEY_IDX_W-1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } cfg_reg_t;

  // running sum after n steps remain: n * delta mod 2^32
  function automatic word_t sum_of(input int unsigned n);
    word_t nw;
    nw = word_t'(n);
    return word_t'(DELTA * nw);
  endfunction

  // sum used by half-round j (even: right update, before step; odd: after step)
  function automatic word_t stage_sum(input int unsigned j);
    int unsigned r;
    r = j / 2;
    if ((j % 2) == 0) begin
      return sum_of(ROUNDS - r);
    end else begin
      return sum_of(ROUNDS - r - 1);
    end
  endfunction

  // key index picked by half-round j
  function automatic logic [KEY_IDX_W-1:0] stage_key_sel(input int unsigned j);
    word_t s;
    s = stage_sum(j);
    if ((j % 2) == 0) begin
      return s[12:11];
    end else begin
      return s[1:0];
    end
  endfunction

  // amount subtracted in one half-round
  function automatic word_t mix_term(input word_t other, input word_t s, input word_t k);
    word_t shx;
    shx = (other >> 5) ^ (other << 4);
    return shx + k + (s ^ other);
  endfunction

endpackage

@@ sv/tea_variant_block_decrypt.sv @@
// tea_variant_block_decrypt: fully unrolled tea-variant block decipher pipeline
// depends on tvbd_pkg (constants, register codes, round helpers)
//
// Deciphers one 64-bit block (left_word, right_word) per cycle while in_stall
// is low, through 2*ROUNDS = 32 register stages, one half-round per stage: even
// stages update the right word, odd stages the left word. The sustained rate is
// one item per cycle while the skid register is empty, set by the one-stage
// half-round. The sum and key index of each stage are constants, so every
// stage holds a single three-term add and one subtract. A one-entry skid
// register behind the last stage keeps the pipeline moving in the cycle in which
// out_stall first rises, so an item is accepted while a result waits; once
// the skid register is full the whole pipeline holds and in_stall is high.
// Key words reset to the fixed salt values; the user writes them through
// cfg_we/cfg_index/cfg_data while the block is idle, which it does not enforce.
module tea_variant_block_decrypt (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [tvbd_pkg::KEY_IDX_W-1:0]  cfg_index,
  input  logic [tvbd_pkg::WORD_W-1:0]     cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tvbd_pkg::WORD_W-1:0]     in_left_word,
  input  logic [tvbd_pkg::WORD_W-1:0]     in_right_word,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tvbd_pkg::WORD_W-1:0]     out_left_result,
  output logic [tvbd_pkg::WORD_W-1:0]     out_right_result
);

  localparam int unsigned N = tvbd_pkg::STAGES;

  // key registers
  tvbd_pkg::word_t key_r [tvbd_pkg::KEY_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= tvbd_pkg::KEY0_RESET;
      key_r[1] <= tvbd_pkg::KEY1_RESET;
      key_r[2] <= tvbd_pkg::KEY2_RESET;
      key_r[3] <= tvbd_pkg::KEY3_RESET;
    end else if (cfg_we) begin
      case (tvbd_pkg::cfg_reg_t'(cfg_index))
        tvbd_pkg::REG_KEY_WORD_0: key_r[0] <= cfg_data;
        tvbd_pkg::REG_KEY_WORD_1: key_r[1] <= cfg_data;
        tvbd_pkg::REG_KEY_WORD_2: key_r[2] <= cfg_data;
        tvbd_pkg::REG_KEY_WORD_3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline stage registers
  logic            v_r [N];
  tvbd_pkg::word_t l_r [N];
  tvbd_pkg::word_t w_r [N];

  // skid register behind the last stage
  logic            skid_v_r;
  tvbd_pkg::word_t skid_l_r;
  tvbd_pkg::word_t skid_w_r;
  logic            skid_v_nxt;

  // whole pipeline advances unless the skid register is holding an item
  logic adv;
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_stage
      localparam tvbd_pkg::word_t STAGE_SUM = tvbd_pkg::stage_sum(j);
      localparam logic [tvbd_pkg::KEY_IDX_W-1:0] KSEL = tvbd_pkg::stage_key_sel(j);

      logic            v_in;
      tvbd_pkg::word_t l_in;
      tvbd_pkg::word_t w_in;
      tvbd_pkg::word_t l_nxt;
      tvbd_pkg::word_t w_nxt;

      if (j == 0) begin : g_first
        assign v_in = in_valid;
        assign l_in = in_left_word;
        assign w_in = in_right_word;
      end else begin : g_rest
        assign v_in = v_r[j-1];
        assign l_in = l_r[j-1];
        assign w_in = w_r[j-1];
      end

      // even stage: right word update, odd stage: left word update
      if ((j % 2) == 0) begin : g_right
        assign l_nxt = l_in;
        assign w_nxt = w_in - tvbd_pkg::mix_term(l_in, STAGE_SUM, key_r[KSEL]);
      end else begin : g_left
        assign l_nxt = l_in - tvbd_pkg::mix_term(w_in, STAGE_SUM, key_r[KSEL]);
        assign w_nxt = w_in;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j] <= 1'b0;
        end else if (adv) begin
          v_r[j] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          l_r[j] <= l_nxt;
          w_r[j] <= w_nxt;
        end
      end
    end
  endgenerate

  // skid fills when the last stage moves on while the output is stalled,
  // drains when the output is taken
  always_comb begin
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (!out_stall) begin
        skid_v_nxt = 1'b0;
      end
    end else if (v_r[N-1] && out_stall) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_l_r <= l_r[N-1];
      skid_w_r <= w_r[N-1];
    end
  end

  // output side: skid entry first, else the last stage
  assign out_valid        = skid_v_r || v_r[N-1];
  assign out_left_result  = skid_v_r ? skid_l_r : l_r[N-1];
  assign out_right_result = skid_v_r ? skid_w_r : w_r[N-1];

`ifndef SYNTHESIS
  // skid fills only from a stalled result at the pipeline tail
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(v_r[N-1] && out_stall))
    else $error("skid filled without a stalled tail result");

  // a held skid item is presented unchanged
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_stall) |=> (skid_v_r && $stable(skid_l_r) && $stable(skid_w_r)))
    else $error("skid item lost or changed while stalled");

  // while the skid holds, the tail stage does not move
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> ($stable(l_r[N-1]) && $stable(w_r[N-1])))
    else $error("pipeline tail moved while skid full");
`endif

endmodule

@@ bench/tb_tea_variant_block_decrypt.sv @@
// tb_tea_variant_block_decrypt: self-checking bench for the tea-variant block decipher
// depends on tvbd_pkg and tea_variant_block_decrypt; predicts every result in-bench
module tb_tea_variant_block_decrypt;

  // cycles with no accepted item on either channel before the run is called hung
  localparam int unsigned IDLE_LIMIT   = 2000;
  // pipeline depth plus skid, rounded up: quiet time allowed after the last result
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned ROW_COUNT    = 10;

  // directed blocks, left word in the upper half; a 16-round decipher gives no
  // result that can be read off by eye, so every row goes through the predictor
  localparam logic [63:0] DIRECTED_ROWS [ROW_COUNT] = '{
    64'h0000_0000_0000_0000,  // both words zero
    64'hFFFF_FFFF_FFFF_FFFF,  // both words all ones
    64'h0000_0000_FFFF_FFFF,  // zero left, ones right
    64'hFFFF_FFFF_0000_0000,  // ones left, zero right
    64'h8000_0000_0000_0001,  // top bit left, bottom bit right
    64'h0000_0001_8000_0000,  // bottom bit left, top bit right
    64'hAAAA_AAAA_5555_5555,  // alternating bits
    64'h5555_5555_AAAA_AAAA,
    64'h7FFF_FFFF_FFFF_FFFE,  // near-extremes
    64'h0123_4567_89AB_CDEF   // mixed pattern
  };

  typedef struct packed {
    tvbd_pkg::word_t left;
    tvbd_pkg::word_t right;
  } block_t;

  typedef logic [tvbd_pkg::KEY_COUNT-1:0] key_mask_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  logic  [tvbd_pkg::KEY_IDX_W-1:0] cfg_index;
  tvbd_pkg::word_t cfg_data;
  logic  in_valid;
  logic  in_stall;
  tvbd_pkg::word_t in_left_word;
  tvbd_pkg::word_t in_right_word;
  logic  out_valid;
  logic  out_stall = 1'b0;
  tvbd_pkg::word_t out_left_result;
  tvbd_pkg::word_t out_right_result;

  // bench copy of the key registers, updated at each write edge
  tvbd_pkg::word_t key_bank [tvbd_pkg::KEY_COUNT];
  // deciphered blocks still owed by the block, oldest first
  block_t plain_due [$];

  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_run    = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;

  tea_variant_block_decrypt i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_left_word     (in_left_word),
    .in_right_word    (in_right_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_result  (out_left_result),
    .out_right_result (out_right_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor: 16 rounds, right half first with the sum before the step,
  // then left half with the sum after the step
  function automatic block_t decipher(input tvbd_pkg::word_t l_in,
                                      input tvbd_pkg::word_t r_in);
    tvbd_pkg::word_t lw;
    tvbd_pkg::word_t rw;
    tvbd_pkg::word_t acc;
    tvbd_pkg::word_t sub;
    block_t          res;
    lw  = l_in;
    rw  = r_in;
    acc = '0;
    for (int n = 0; n < tvbd_pkg::ROUNDS; n++) acc = acc + tvbd_pkg::DELTA;
    for (int n = 0; n < tvbd_pkg::ROUNDS; n++) begin
      // right-word term keys off sum bits 12..11
      sub = ((lw >> 5) ^ (lw << 4)) + key_bank[acc[12:11]] + (acc ^ lw);
      acc = acc - tvbd_pkg::DELTA;
      rw  = rw - sub;
      // left-word term keys off sum bits 1..0 of the stepped sum
      sub = ((rw >> 5) ^ (rw << 4)) + key_bank[acc[1:0]] + (acc ^ rw);
      lw  = lw - sub;
    end
    res.left  = lw;
    res.right = rw;
    return res;
  endfunction

  task automatic flag(input string what, input tvbd_pkg::word_t got,
                      input tvbd_pkg::word_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // mostly random words, with a fair share of zeros, ones and walking bits
  function automatic tvbd_pkg::word_t pick_word();
    tvbd_pkg::word_t bit1;
    bit1 = tvbd_pkg::word_t'(1) << $urandom_range(0, tvbd_pkg::WORD_W - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return bit1;
      3:       return ~bit1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 6;
      default: return 25;
    endcase
  endfunction

  // write the masked key registers back to back, one per cycle
  task automatic load_keys(input tvbd_pkg::word_t vals [tvbd_pkg::KEY_COUNT],
                           input key_mask_t mask);
    for (int i = 0; i < tvbd_pkg::KEY_COUNT; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= tvbd_pkg::cfg_reg_t'(i);
        cfg_data  <= vals[i];
        @(posedge clk);
        key_bank[i] = vals[i];
      end
    end
    cfg_we <= 1'b0;
  endtask

  // offer one block, with an optional hold-off first; returns at the accept edge
  task automatic send_block(input tvbd_pkg::word_t l, input tvbd_pkg::word_t r);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_left_word  <= l;
    in_right_word <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plain_due.push_back(decipher(l, r));
  endtask

  // stop sending and wait until every owed block has come out
  task automatic drain_blocks();
    in_valid <= 1'b0;
    while (plain_due.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure: random bursts of stalled cycles at the phase rate
  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
      stall_run <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: every accepted result against the oldest owed block
  always @(posedge clk) begin : result_check
    block_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (plain_due.size() == 0) begin
        flag("unexpected result left", out_left_result, '0);
      end else begin
        want = plain_due.pop_front();
        if (out_left_result !== want.left) begin
          flag("left_result", out_left_result, want.left);
        end
        if (out_right_result !== want.right) begin
          flag("right_result", out_right_result, want.right);
        end
      end
    end
  end

  // hang detector: counts cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[tea_variant_block_decrypt] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    tvbd_pkg::word_t keys [tvbd_pkg::KEY_COUNT];
    key_mask_t       mask;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = tvbd_pkg::REG_KEY_WORD_0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_left_word  = '0;
    in_right_word = '0;
    key_bank      = '{tvbd_pkg::KEY0_RESET, tvbd_pkg::KEY1_RESET,
                      tvbd_pkg::KEY2_RESET, tvbd_pkg::KEY3_RESET};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: the table under the reset salts, then under all-zero keys
    send_gap_pct = 0;
    recv_gap_pct = 6;
    for (int i = 0; i < ROW_COUNT; i++) begin
      send_block(DIRECTED_ROWS[i][63:32], DIRECTED_ROWS[i][31:0]);
    end
    drain_blocks();
    keys = '{'0, '0, '0, '0};
    load_keys(keys, '1);
    for (int i = 0; i < ROW_COUNT; i++) begin
      send_block(DIRECTED_ROWS[i][63:32], DIRECTED_ROWS[i][31:0]);
    end

    // random phases, each under its own key setting and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      // key writes only with the pipeline empty
      drain_blocks();
      for (int i = 0; i < tvbd_pkg::KEY_COUNT; i++) keys[i] = $urandom;
      mask = '1;
      case (ph)
        0: keys = '{'1, '1, '1, '1};
        2: mask = key_mask_t'($urandom_range(1, 15));
        3: keys = '{'0, '1, '0, '1};
        4: keys = '{'1, '0, '1, '0};
        5: mask = key_mask_t'($urandom_range(1, 15));
        6: keys = '{tvbd_pkg::KEY0_RESET, tvbd_pkg::KEY1_RESET,
                    tvbd_pkg::KEY2_RESET, tvbd_pkg::KEY3_RESET};
        default: ;
      endcase
      load_keys(keys, mask);

      // last phase runs flat out on both sides
      if (ph == PHASES - 1) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else begin
        send_gap_pct = pick_rate();
        recv_gap_pct = pick_rate();
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase pause on odd phases: sender waits for every owed result
        if (ph % 2 == 1 && n == PHASE_ITEMS / 2) begin
          drain_blocks();
        end
        send_block(pick_word(), pick_word());
      end
    end

    drain_blocks();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && plain_due.size() == 0) begin
      $display("[tea_variant_block_decrypt] OK");
    end else begin
      $display("[tea_variant_block_decrypt] ERROR");
    end
    $finish;
  end

endmodule
